// File: design/gbn_pkg.sv
// Shared constants, types and helper functions for the Go-Back-N sender window.
`default_nettype none
package gbn_pkg;

	localparam int SEQ_COUNT = 20;
	localparam int WINDOW    = 10;
	localparam int SEQ_W     = $clog2(SEQ_COUNT);
	localparam int CMP_W     = 9;
	localparam int CNT_W     = 8;
	localparam int CFG_W     = 16;
	localparam int WALK      = (WINDOW < SEQ_COUNT) ? WINDOW : SEQ_COUNT;

	localparam logic [1:0] KIND_SEND = 2'd0;
	localparam logic [1:0] KIND_ACK  = 2'd1;
	localparam logic [1:0] KIND_POLL = 2'd2;

	localparam logic CFG_TOTAL = 1'b0;
	localparam logic CFG_WAIT  = 1'b1;

	localparam logic [15:0] TOTAL_RESET = 16'd25;
	localparam logic [7:0]  WAIT_RESET  = 8'd20;

	typedef logic [SEQ_W-1:0] seq_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] ack_number;
	} in_item_t;

	typedef struct packed {
		logic        send_valid;
		logic [7:0]  send_seq;
		logic [15:0] packet_index;
		logic        timed_out;
		logic        ack_rejected;
		logic        all_acked;
	} out_item_t;

	typedef struct packed {
		logic rd_en;
		seq_t rd_addr;
		logic wr_en;
		seq_t wr_addr;
		logic wr_used;
	} slot_req_t;

	function automatic seq_t seq_inc(seq_t s);
		return (s == SEQ_W'(SEQ_COUNT - 1)) ? '0 : s + 1'b1;
	endfunction

	function automatic seq_t ring_dist(seq_t to, seq_t from);
		logic [CMP_W-1:0] wrapped;
		wrapped = CMP_W'(to) + CMP_W'(SEQ_COUNT) - CMP_W'(from);
		return (to >= from) ? seq_t'(to - from) : wrapped[SEQ_W-1:0];
	endfunction

endpackage
`default_nettype wire

// File: design/gbn_slot_store.sv
// Slot occupancy memory with per-entry valid bits; unwritten entries read as free.
`default_nettype none
module gbn_slot_store (
	input  wire                  clk,
	input  wire                  arst_n,
	input  gbn_pkg::slot_req_t   req,
	output logic                 rd_free
);
	import gbn_pkg::*;

	logic                 used_mem [SEQ_COUNT];
	logic [SEQ_COUNT-1:0] valid_q;
	logic                 rd_used_q;
	logic                 rd_valid_q;

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			used_mem[req.wr_addr] <= req.wr_used;
		end
		if (req.rd_en) begin
			rd_used_q <= used_mem[req.rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (req.wr_en) begin
				valid_q[req.wr_addr] <= 1'b1;
			end
			if (req.rd_en) begin
				rd_valid_q <= valid_q[req.rd_addr];
			end
		end
	end

	assign rd_free = !(rd_valid_q && rd_used_q);

endmodule
`default_nettype wire

// File: design/gbn_sender_window.sv
// Top level of the Go-Back-N sender window: sequencer, counters and configuration.
//
//   channel   signals                      beat taken when
//   --------  ---------------------------  ------------------------
//   item      start, busy, item            start high, busy low
//   result    done, result                 done high (one cycle)
//   config    cfg_we, cfg_index, cfg_data  cfg_we high
//
// An item that needs no slot memory access keeps busy low; the next may follow at
// once. A granted send checks its slot in ST_SEND. An accepted ack frees d + 1 slots
// in ST_ACK, d being its distance from the window base, one slot write per cycle. A
// timeout walks min(WINDOW, SEQ_COUNT) slots in ST_TIMEOUT, one slot read and write
// per cycle. Reset leaves every slot free. The result beat cannot be stalled.
`default_nettype none
module gbn_sender_window (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  start,
	output logic                 busy,
	input  gbn_pkg::in_item_t    item,
	output logic                 done,
	output gbn_pkg::out_item_t   result,
	input  wire                  cfg_we,
	input  wire                  cfg_index,
	input  wire [gbn_pkg::CFG_W-1:0] cfg_data
);
	import gbn_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SEND,
		ST_ACK,
		ST_TIMEOUT
	} state_t;

	state_t      state_q;
	seq_t        next_q;
	seq_t        base_q;
	logic [15:0] sent_q;
	logic [15:0] acked_q;
	logic [7:0]  idle_q;
	logic [15:0] total_q;
	logic [7:0]  wait_q;
	seq_t        walk_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] undone_q;
	seq_t        dist_q;
	seq_t        slot_q;
	logic        done_q;
	out_item_t   result_q;

	slot_req_t   req;
	logic        rd_free;

	seq_t        step;
	logic        grant_ok;
	logic        ack_ok;
	seq_t        ack_slot;
	seq_t        ack_d;
	logic        expired;
	logic [CNT_W-1:0] undone_sum;
	logic [15:0] acked_inc;
	logic [7:0]  ack_m1;

	gbn_slot_store u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.rd_free (rd_free)
	);

	assign step       = ring_dist(next_q, base_q);
	assign grant_ok   = (CMP_W'(step) < CMP_W'(WINDOW)) && (sent_q < total_q);
	assign ack_ok     = (item.ack_number != 8'd0) && (item.ack_number <= 8'(SEQ_COUNT));
	assign ack_m1     = item.ack_number - 8'd1;
	assign ack_slot   = ack_m1[SEQ_W-1:0];
	assign ack_d      = ring_dist(ack_slot, base_q);
	assign expired    = idle_q >= wait_q;
	assign undone_sum = undone_q + CNT_W'(!rd_free);
	assign acked_inc  = acked_q + 16'(dist_q) + 16'd1;

	always_comb begin
		req = '0;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					if (item.kind == KIND_SEND && grant_ok) begin
						req.rd_en   = 1'b1;
						req.rd_addr = next_q;
					end else if (item.kind == KIND_POLL && expired) begin
						req.rd_en   = 1'b1;
						req.rd_addr = base_q;
					end
				end
			end
			ST_SEND: begin
				req.wr_en   = rd_free;
				req.wr_addr = next_q;
				req.wr_used = 1'b1;
			end
			ST_ACK: begin
				req.wr_en   = 1'b1;
				req.wr_addr = walk_ptr_q;
				req.wr_used = 1'b0;
			end
			ST_TIMEOUT: begin
				req.wr_en   = 1'b1;
				req.wr_addr = walk_ptr_q;
				req.wr_used = 1'b0;
				req.rd_en   = (cnt_q != '0);
				req.rd_addr = seq_inc(walk_ptr_q);
			end
			default: begin
				req = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= TOTAL_RESET;
			wait_q  <= WAIT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_TOTAL: total_q <= cfg_data;
				CFG_WAIT:  wait_q  <= cfg_data[7:0];
				default:   total_q <= total_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			next_q     <= '0;
			base_q     <= '0;
			sent_q     <= '0;
			acked_q    <= '0;
			idle_q     <= '0;
			walk_ptr_q <= '0;
			cnt_q      <= '0;
			undone_q   <= '0;
			dist_q     <= '0;
			slot_q     <= '0;
			done_q     <= 1'b0;
			result_q   <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						result_q           <= '0;
						result_q.all_acked <= (acked_q == total_q);
						case (item.kind)
							KIND_SEND: begin
								if (grant_ok) begin
									state_q <= ST_SEND;
								end else begin
									done_q <= 1'b1;
								end
							end
							KIND_ACK: begin
								if (!ack_ok) begin
									result_q.ack_rejected <= 1'b1;
									done_q                <= 1'b1;
								end else begin
									idle_q <= '0;
									if (ack_d < step) begin
										walk_ptr_q <= base_q;
										cnt_q      <= CNT_W'(ack_d);
										dist_q     <= ack_d;
										slot_q     <= ack_slot;
										state_q    <= ST_ACK;
									end else begin
										done_q <= 1'b1;
									end
								end
							end
							KIND_POLL: begin
								if (expired) begin
									walk_ptr_q <= base_q;
									cnt_q      <= CNT_W'(WALK - 1);
									undone_q   <= '0;
									state_q    <= ST_TIMEOUT;
								end else begin
									idle_q <= idle_q + 8'd1;
									done_q <= 1'b1;
								end
							end
							default: begin
								done_q <= 1'b1;
							end
						endcase
					end
				end
				ST_SEND: begin
					if (rd_free) begin
						result_q.send_valid   <= 1'b1;
						result_q.send_seq     <= 8'(next_q) + 8'd1;
						result_q.packet_index <= sent_q;
						next_q                <= seq_inc(next_q);
						sent_q                <= sent_q + 16'd1;
					end
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				ST_ACK: begin
					if (cnt_q == '0) begin
						acked_q            <= acked_inc;
						base_q             <= seq_inc(slot_q);
						result_q.all_acked <= (acked_inc == total_q);
						done_q             <= 1'b1;
						state_q            <= ST_IDLE;
					end else begin
						walk_ptr_q <= seq_inc(walk_ptr_q);
						cnt_q      <= cnt_q - 1'b1;
					end
				end
				ST_TIMEOUT: begin
					if (cnt_q == '0) begin
						sent_q <= (16'(undone_sum) > sent_q) ? 16'd0
							: sent_q - 16'(undone_sum);
						next_q             <= base_q;
						idle_q             <= '0;
						result_q.timed_out <= 1'b1;
						done_q             <= 1'b1;
						state_q            <= ST_IDLE;
					end else begin
						walk_ptr_q <= seq_inc(walk_ptr_q);
						cnt_q      <= cnt_q - 1'b1;
						undone_q   <= undone_sum;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy   = (state_q != ST_IDLE);
	assign done   = done_q;
	assign result = result_q;

endmodule
`default_nettype wire

// File: sim/tb.sv
// Self-checking testbench for the Go-Back-N sender window against a behavioral window model.
`default_nettype none
module tb;
	import gbn_pkg::*;

	localparam logic [1:0] KIND_SPARE = 2'd3;
	localparam int SETTLE = SEQ_COUNT + WINDOW + 8;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	in_item_t item = '0;
	logic cfg_we = 1'b0;
	logic cfg_index = 1'b0;
	logic [15:0] cfg_data = '0;
	logic busy;
	logic done;
	out_item_t result;

	logic [SEQ_COUNT-1:0] slot_idle;
	int unsigned seq_next;
	int unsigned seq_base;
	logic [15:0] n_sent;
	logic [15:0] n_acked;
	logic [7:0] n_polls;
	logic [15:0] total_pk;
	logic [7:0] poll_limit;
	out_item_t pending_results[$];
	int errors = 0;

	gbn_sender_window u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.item(item),
		.done(done),
		.result(result),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("Verification failed");
		$finish;
	end

	function automatic int unsigned seq_dist(int unsigned to, int unsigned from);
		return (to + SEQ_COUNT - from) % SEQ_COUNT;
	endfunction

	function automatic out_item_t window_predict(in_item_t it);
		out_item_t r;
		int unsigned d;
		int unsigned span;
		int unsigned undone;
		int unsigned k;
		int unsigned i;
		r = '0;
		case (it.kind)
			KIND_SEND: begin
				if (seq_dist(seq_next, seq_base) < WINDOW && slot_idle[seq_next] &&
						n_sent < total_pk) begin
					r.send_valid = 1'b1;
					r.send_seq = 8'(seq_next + 1);
					r.packet_index = n_sent;
					slot_idle[seq_next] = 1'b0;
					seq_next = (seq_next + 1) % SEQ_COUNT;
					n_sent = n_sent + 16'd1;
				end
			end
			KIND_ACK: begin
				if (it.ack_number < 1 || it.ack_number > SEQ_COUNT) begin
					r.ack_rejected = 1'b1;
				end else begin
					d = seq_dist(int'(it.ack_number) - 1, seq_base);
					span = seq_dist(seq_next, seq_base);
					n_polls = '0;
					if (d < span) begin
						for (i = 0; i <= d; i++)
							slot_idle[(seq_base + i) % SEQ_COUNT] = 1'b1;
						n_acked = n_acked + 16'(d + 1);
						seq_base = int'(it.ack_number) % SEQ_COUNT;
					end
				end
			end
			KIND_POLL: begin
				if (n_polls >= poll_limit) begin
					undone = 0;
					for (i = 0; i < WINDOW && i < SEQ_COUNT; i++) begin
						k = (seq_base + i) % SEQ_COUNT;
						if (!slot_idle[k])
							undone++;
						slot_idle[k] = 1'b1;
					end
					n_sent = (undone > n_sent) ? 16'd0 : n_sent - 16'(undone);
					seq_next = seq_base;
					n_polls = '0;
					r.timed_out = 1'b1;
				end else begin
					n_polls = n_polls + 8'd1;
				end
			end
			default: begin
			end
		endcase
		r.all_acked = (n_acked == total_pk);
		return r;
	endfunction

	function automatic in_item_t mk(logic [1:0] kind, logic [7:0] ack);
		in_item_t it;
		it.kind = kind;
		it.ack_number = ack;
		return it;
	endfunction

	// Mostly acks that land on outstanding slots, some stale, a few out of range.
	function automatic logic [7:0] pick_ack();
		int unsigned span;
		int unsigned roll;
		span = seq_dist(seq_next, seq_base);
		roll = $urandom_range(0, 9);
		if (roll < 7 && span > 0)
			return 8'(((seq_base + $urandom_range(0, span - 1)) % SEQ_COUNT) + 1);
		if (roll < 9)
			return 8'($urandom_range(1, SEQ_COUNT));
		return $urandom_range(0, 1) ? 8'd0 : 8'($urandom_range(SEQ_COUNT + 1, 255));
	endfunction

	function automatic in_item_t random_item();
		in_item_t it;
		int unsigned roll;
		it.ack_number = 8'($urandom);
		roll = $urandom_range(0, 99);
		if (roll < 45) begin
			it.kind = KIND_SEND;
		end else if (roll < 75) begin
			it.kind = KIND_ACK;
			it.ack_number = pick_ack();
		end else if (roll < 95) begin
			it.kind = KIND_POLL;
		end else begin
			it.kind = KIND_SPARE;
		end
		return it;
	endfunction

	// Start stays high when the next item follows at once, so it is never lowered and
	// raised in the same step.
	task automatic send_item(in_item_t it);
		int unsigned gap;
		gap = $urandom_range(0, 17);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		item <= it;
		do @(posedge clk); while (busy);
		pending_results.push_back(window_predict(it));
	endtask

	task automatic wait_drained();
		start <= 1'b0;
		@(posedge clk);
		while (pending_results.size() > 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [15:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		if (idx == CFG_TOTAL)
			total_pk = value;
		else
			poll_limit = value[7:0];
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic compare_field(string name, longint unsigned want, longint unsigned got);
		if (want != got) begin
			errors++;
			$display("%0t: %s expected %0d actual %0d", $time, name, want, got);
		end
	endtask

	// Each result beat is taken at the edge that ends its cycle.
	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				errors++;
				$display("%0t: unexpected result expected none actual %p", $time, result);
			end else begin
				want = pending_results.pop_front();
				compare_field("send_valid", want.send_valid, result.send_valid);
				compare_field("send_seq", want.send_seq, result.send_seq);
				compare_field("packet_index", want.packet_index, result.packet_index);
				compare_field("timed_out", want.timed_out, result.timed_out);
				compare_field("ack_rejected", want.ack_rejected, result.ack_rejected);
				compare_field("all_acked", want.all_acked, result.all_acked);
			end
		end
	end

	task automatic test_directed();
		send_item(mk(KIND_SPARE, 8'hFF));
		send_item(mk(KIND_ACK, 8'd0));
		send_item(mk(KIND_ACK, 8'(SEQ_COUNT + 1)));
		send_item(mk(KIND_ACK, 8'hFF));
		send_item(mk(KIND_ACK, 8'd5));
		repeat (WINDOW + 1) send_item(mk(KIND_SEND, 8'($urandom)));
		send_item(mk(KIND_ACK, 8'd3));
		send_item(mk(KIND_ACK, 8'd2));
		send_item(mk(KIND_ACK, 8'(SEQ_COUNT)));
		send_item(mk(KIND_ACK, 8'd10));
		send_item(mk(KIND_POLL, 8'd0));
		wait_drained();
		write_reg(CFG_WAIT, 16'hFF00);
		send_item(mk(KIND_POLL, 8'hAA));
		send_item(mk(KIND_SEND, 8'h55));
		send_item(mk(KIND_POLL, 8'h00));
		wait_drained();
	endtask

	task automatic test_session_limits();
		write_reg(CFG_TOTAL, 16'd0);
		write_reg(CFG_WAIT, 16'd1);
		send_item(mk(KIND_SEND, 8'h00));
		send_item(mk(KIND_POLL, 8'h00));
		send_item(mk(KIND_POLL, 8'h00));
		wait_drained();
		write_reg(CFG_TOTAL, n_acked + 16'd3);
		repeat (5) send_item(mk(KIND_SEND, 8'($urandom)));
		send_item(mk(KIND_ACK, 8'((seq_next == 0) ? SEQ_COUNT : seq_next)));
		send_item(mk(KIND_SEND, 8'h00));
		wait_drained();
		write_reg(CFG_TOTAL, 16'hFFFF);
		write_reg(CFG_WAIT, 16'h00FF);
		repeat (4) send_item(mk(KIND_SEND, 8'($urandom)));
		send_item(mk(KIND_POLL, 8'h00));
		wait_drained();
	endtask

	task automatic test_random_traffic();
		int ph;
		int n;
		int unsigned limit;
		for (ph = 0; ph < 10; ph++) begin
			case (ph % 5)
				0: limit = 0;
				1: limit = (ph == 1) ? 255 : 1;
				default: limit = $urandom_range(1, 12);
			endcase
			write_reg(CFG_WAIT, {8'($urandom), 8'(limit)});
			if (ph == 2)
				write_reg(CFG_TOTAL, 16'd0);
			else if (ph == 7)
				write_reg(CFG_TOTAL, 16'hFFFF);
			else
				write_reg(CFG_TOTAL, n_acked + 16'(seq_dist(seq_next, seq_base)) +
					16'($urandom_range(1, 60)));
			for (n = 0; n < 100; n++) begin
				if (ph == 4 && n == 50)
					wait_drained();
				send_item(random_item());
			end
			wait_drained();
		end
	endtask

	initial begin
		slot_idle = '1;
		seq_next = 0;
		seq_base = 0;
		n_sent = '0;
		n_acked = '0;
		n_polls = '0;
		total_pk = TOTAL_RESET;
		poll_limit = WAIT_RESET;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_session_limits();
		test_random_traffic();
		wait_drained();
		if (errors == 0 && pending_results.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
`default_nettype wire
